### rtl/text_console_char_writer_top_defines.svh
// Assertion macros for the text console writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH

`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/tcw_pkg.sv
package tcw_pkg;
	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = ROWS * COLS;
	localparam int AW = $clog2(CELLS);
	localparam int CW = 7;
	localparam int RW = 5;
	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [1:0] ACT_PUT = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  char_code;
		logic [RW-1:0] read_row;
		logic [CW-1:0] read_col;
	} req_t;

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
		logic [AW+RW+CW-1:0] a;
		a = (AW+RW+CW)'(r) * (AW+RW+CW)'(COLS) + (AW+RW+CW)'(c);
		return a[AW-1:0];
	endfunction
endpackage

### rtl/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/tcw_front.sv
module tcw_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           blocked,
	input  tcw_pkg::req_t  req,
	input  logic           pop,
	output logic           busy,
	output logic           q_valid,
	output tcw_pkg::req_t  q_head
);
	tcw_pkg::req_t q_q [tcw_pkg::QDEPTH];
	logic [1:0] cnt_q;
	logic push;

	assign busy = blocked || (cnt_q == 2'(tcw_pkg::QDEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = q_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			q_q[0] <= (push && cnt_q[0]) ? req : q_q[1];
			if (push && !cnt_q[0]) q_q[1] <= req;
		end else if (push) begin
			q_q[cnt_q[0]] <= req;
		end
	end
endmodule

### rtl/tcw_back.sv
module tcw_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [7:0]             cfg_wdata,
	input  logic                   q_valid,
	input  tcw_pkg::req_t          q_head,
	output logic                   pop,
	output logic                   blocked,
	output logic                   done,
	output logic [7:0]             cell_char,
	output logic [7:0]             cell_attr,
	output logic [tcw_pkg::CW-1:0] cursor_col_out,
	output logic [tcw_pkg::RW-1:0] cursor_row_out
);
	localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2, S_BS = 3'd3,
		S_SCR_RD = 3'd4, S_SCR_WR = 3'd5, S_FILL = 3'd6;
	localparam int AW = tcw_pkg::AW;
	localparam int CW = tcw_pkg::CW;
	localparam int RW = tcw_pkg::RW;
	localparam logic [AW-1:0] LAST = AW'(tcw_pkg::CELLS - 1);
	localparam logic [AW-1:0] BOT = AW'((tcw_pkg::ROWS - 1) * tcw_pkg::COLS);

	logic [2:0] st_q;
	logic [7:0] attr_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] ptr_q, waddr_q;
	logic done_q, rd_q;
	logic [7:0] och_q, oat_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0] wdata, rdata;

	tcw_ram #(.WIDTH(16), .DEPTH(tcw_pkg::CELLS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [CW:0] tab_col;
	logic in_rng;
	assign tab_col = ({1'b0, col_q} + (CW+1)'(8)) & ~(CW+1)'(7);
	assign in_rng = (q_head.read_row < RW'(tcw_pkg::ROWS)) &&
		(q_head.read_col < CW'(tcw_pkg::COLS));

	assign blocked = (st_q == S_INIT);
	assign pop = (st_q == S_IDLE) && q_valid;
	assign done = done_q;
	assign cell_char = och_q;
	assign cell_attr = oat_q;
	assign cursor_col_out = col_q;
	assign cursor_row_out = row_q;

	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wdata = {attr_q, tcw_pkg::SPACE};
		raddr = tcw_pkg::addr_of(q_head.read_row, q_head.read_col);
		unique case (st_q)
			S_INIT: begin
				we = 1'b1;
				wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE};
			end
			S_FILL: we = 1'b1;
			S_BS: begin
				we = 1'b1;
				waddr = waddr_q;
				wdata = {rdata[15:8], tcw_pkg::SPACE};
			end
			S_SCR_RD: raddr = ptr_q + AW'(tcw_pkg::COLS);
			S_SCR_WR: begin
				we = 1'b1;
				wdata = rdata;
				raddr = ptr_q + AW'(tcw_pkg::COLS);
			end
			S_IDLE: begin
				if (pop && q_head.action == tcw_pkg::ACT_PUT) begin
					raddr = tcw_pkg::addr_of(row_q, col_q - CW'(1));
					if (q_head.char_code != tcw_pkg::CH_NL && q_head.char_code != tcw_pkg::CH_CR
						&& q_head.char_code != tcw_pkg::CH_TAB && q_head.char_code != tcw_pkg::CH_BS) begin
						we = 1'b1;
						waddr = tcw_pkg::addr_of(row_q, col_q);
						wdata = {attr_q, q_head.char_code};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
			attr_q <= tcw_pkg::ATTR_RESET;
			col_q <= '0;
			row_q <= '0;
			ptr_q <= '0;
			waddr_q <= '0;
			done_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			logic dn;
			dn = 1'b0;
			if (cfg_we) attr_q <= cfg_wdata;
			unique case (st_q)
				S_INIT: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pop) begin
						unique case (q_head.action)
							tcw_pkg::ACT_PUT: begin
								logic nl;
								nl = 1'b0;
								if (q_head.char_code == tcw_pkg::CH_NL) begin
									nl = 1'b1;
								end else if (q_head.char_code == tcw_pkg::CH_CR) begin
									col_q <= '0;
									dn = 1'b1;
								end else if (q_head.char_code == tcw_pkg::CH_TAB) begin
									if (tab_col >= (CW+1)'(tcw_pkg::COLS)) nl = 1'b1;
									else begin
										col_q <= tab_col[CW-1:0];
										dn = 1'b1;
									end
								end else if (q_head.char_code == tcw_pkg::CH_BS) begin
									if (col_q != '0) begin
										col_q <= col_q - CW'(1);
										waddr_q <= tcw_pkg::addr_of(row_q, col_q - CW'(1));
										st_q <= S_BS;
									end else begin
										if (row_q != '0) begin
											row_q <= row_q - RW'(1);
											col_q <= CW'(tcw_pkg::COLS - 1);
										end
										dn = 1'b1;
									end
								end else begin
									if (col_q == CW'(tcw_pkg::COLS - 1)) nl = 1'b1;
									else begin
										col_q <= col_q + CW'(1);
										dn = 1'b1;
									end
								end
								if (nl) begin
									col_q <= '0;
									if (row_q == RW'(tcw_pkg::ROWS - 1)) begin
										ptr_q <= '0;
										st_q <= S_SCR_RD;
									end else begin
										row_q <= row_q + RW'(1);
										dn = 1'b1;
									end
								end
							end
							tcw_pkg::ACT_READ: begin
								st_q <= S_READ;
								rd_q <= in_rng;
							end
							tcw_pkg::ACT_CLEAR: begin
								col_q <= '0;
								row_q <= '0;
								ptr_q <= '0;
								st_q <= S_FILL;
							end
							default: dn = 1'b1;
						endcase
					end
				end
				S_READ: begin
					dn = 1'b1;
					st_q <= S_IDLE;
				end
				S_BS: begin
					dn = 1'b1;
					st_q <= S_IDLE;
				end
				S_SCR_RD: st_q <= S_SCR_WR;
				S_SCR_WR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == BOT - AW'(1)) st_q <= S_FILL;
					else st_q <= S_SCR_RD;
				end
				S_FILL: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST) begin
						dn = 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			done_q <= dn;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_READ) begin
			och_q <= rd_q ? rdata[7:0] : 8'd0;
			oat_q <= rd_q ? rdata[15:8] : 8'd0;
		end else if (st_q != S_INIT) begin
			och_q <= 8'd0;
			oat_q <= 8'd0;
		end
	end
endmodule

### rtl/text_console_char_writer_top.sv
// Text console character writer.
// Requests enter on start when busy is low: action, char_code, read_row,
// read_col. Each request yields one result, shown for one cycle with done:
// cell_char and cell_attr (read cell, else zero) and the cursor afterwards.
// A two-entry queue sits between the request side and the screen engine,
// so requests may be taken while the engine works.
// Printable, CR, tab and newline without scroll finish on the pop; read,
// and backspace that erases a cell, pass through S_READ or S_BS. A scroll
// reads (S_SCR_RD) and writes (S_SCR_WR) each moved cell, then blanks the
// bottom row (S_FILL); clear blanks all 2000 cells. Sustained rate is one
// request per cycle for plain text while no scroll, read, erasing
// backspace or clear holds the engine. text_attr_we/text_attr_data write
// the attribute register at any edge. After reset the store is blanked
// while busy is high. The receiver cannot stall: done is a one-cycle strobe.
`include "text_console_char_writer_top_defines.svh"
module text_console_char_writer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	input  logic       text_attr_we,
	input  logic [7:0] text_attr_data,
	output logic       done,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr,
	output logic [6:0] cursor_col_out,
	output logic [4:0] cursor_row_out
);
	tcw_pkg::req_t req, q_head;
	logic blocked, pop, q_valid;

	assign req = '{action: action, char_code: char_code, read_row: read_row, read_col: read_col};

	tcw_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .blocked(blocked), .req(req),
		.pop(pop), .busy(busy), .q_valid(q_valid), .q_head(q_head)
	);

	tcw_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(text_attr_we), .cfg_wdata(text_attr_data),
		.q_valid(q_valid), .q_head(q_head), .pop(pop), .blocked(blocked), .done(done),
		.cell_char(cell_char), .cell_attr(cell_attr),
		.cursor_col_out(cursor_col_out), .cursor_row_out(cursor_row_out)
	);

	`TCW_ASSERT_IMPL(a_pop_valid, clk, arst_n, pop, q_valid)
	`TCW_ASSERT_IMPL(a_col_rng, clk, arst_n, 1'b1, cursor_col_out < 7'(tcw_pkg::COLS))
	`TCW_ASSERT_IMPL(a_row_rng, clk, arst_n, 1'b1, cursor_row_out < 5'(tcw_pkg::ROWS))
	`TCW_ASSERT_NEXT(a_no_done_init, clk, arst_n, blocked, !done)
endmodule

### tb/sv/text_console_char_writer_top_tb.sv
module text_console_char_writer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		bit         is_attr_write;
		bit         drain;
		int         gap;
		logic [1:0] action;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
		logic [7:0] attr;
	} console_req_t;

	typedef struct {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [6:0] col;
		logic [4:0] row;
	} console_view_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] action = 0;
	logic [7:0] char_code = 0;
	logic [4:0] read_row = 0;
	logic [6:0] read_col = 0;
	logic text_attr_we = 0;
	logic [7:0] text_attr_data = 0;
	logic done;
	logic [7:0] cell_char, cell_attr;
	logic [6:0] cursor_col_out;
	logic [4:0] cursor_row_out;

	text_console_char_writer_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .char_code(char_code), .read_row(read_row), .read_col(read_col),
		.text_attr_we(text_attr_we), .text_attr_data(text_attr_data),
		.done(done), .cell_char(cell_char), .cell_attr(cell_attr),
		.cursor_col_out(cursor_col_out), .cursor_row_out(cursor_row_out)
	);

	console_req_t  pending_reqs[$];
	console_view_t expected_views[$];
	logic [15:0]   shadow_screen [0:tcw_pkg::CELLS-1];
	int            shadow_col, shadow_row;
	logic [7:0]    shadow_attr;
	int            mismatches = 0;
	int            gap_count = 0;
	int            idle_count = 0;

	initial forever #10 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic shadow_next_line();
		shadow_col = 0;
		shadow_row++;
		if (shadow_row >= tcw_pkg::ROWS) begin
			for (int i = 0; i < (tcw_pkg::ROWS - 1) * tcw_pkg::COLS; i++)
				shadow_screen[i] = shadow_screen[i + tcw_pkg::COLS];
			for (int i = (tcw_pkg::ROWS - 1) * tcw_pkg::COLS; i < tcw_pkg::CELLS; i++)
				shadow_screen[i] = {shadow_attr, tcw_pkg::SPACE};
			shadow_row = tcw_pkg::ROWS - 1;
		end
	endtask

	task automatic console_step(input console_req_t r);
		console_view_t v;
		int pos;
		v.cell_char = 0;
		v.cell_attr = 0;
		if (r.action == tcw_pkg::ACT_PUT) begin
			if (r.char_code == tcw_pkg::CH_NL) begin
				shadow_next_line();
			end else if (r.char_code == tcw_pkg::CH_CR) begin
				shadow_col = 0;
			end else if (r.char_code == tcw_pkg::CH_TAB) begin
				shadow_col = (shadow_col + 8) & ~7;
				if (shadow_col >= tcw_pkg::COLS) shadow_next_line();
			end else if (r.char_code == tcw_pkg::CH_BS) begin
				if (shadow_col > 0) begin
					shadow_col--;
					pos = shadow_row * tcw_pkg::COLS + shadow_col;
					shadow_screen[pos][7:0] = tcw_pkg::SPACE;
				end else if (shadow_row > 0) begin
					shadow_row--;
					shadow_col = tcw_pkg::COLS - 1;
				end
			end else begin
				shadow_screen[shadow_row * tcw_pkg::COLS + shadow_col] = {shadow_attr, r.char_code};
				shadow_col++;
				if (shadow_col >= tcw_pkg::COLS) shadow_next_line();
			end
		end else if (r.action == tcw_pkg::ACT_READ) begin
			if (r.read_row < tcw_pkg::ROWS && r.read_col < tcw_pkg::COLS) begin
				pos = r.read_row * tcw_pkg::COLS + r.read_col;
				v.cell_char = shadow_screen[pos][7:0];
				v.cell_attr = shadow_screen[pos][15:8];
			end
		end else if (r.action == tcw_pkg::ACT_CLEAR) begin
			for (int i = 0; i < tcw_pkg::CELLS; i++) shadow_screen[i] = {shadow_attr, tcw_pkg::SPACE};
			shadow_col = 0;
			shadow_row = 0;
		end
		v.col = shadow_col[6:0];
		v.row = shadow_row[4:0];
		expected_views.push_back(v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			text_attr_we <= 0;
			gap_count <= 0;
			idle_count <= 0;
		end else begin
			console_req_t r;
			bit we_n;
			int idle_n;
			we_n = 0;
			idle_n = (expected_views.size() == 0 && !busy && !start) ? idle_count + 1 : 0;
			if (start && !busy) begin
				start <= 0;
			end else if (!start && pending_reqs.size() > 0) begin
				r = pending_reqs[0];
				if (gap_count < r.gap) begin
					gap_count <= gap_count + 1;
				end else if (r.is_attr_write) begin
					if (idle_count > 8) begin
						we_n = 1;
						text_attr_data <= r.attr;
						shadow_attr = r.attr;
						void'(pending_reqs.pop_front());
						gap_count <= 0;
						idle_n = 0;
					end
				end else if (!r.drain || expected_views.size() == 0) begin
					start <= 1;
					action <= r.action;
					char_code <= r.char_code;
					read_row <= r.read_row;
					read_col <= r.read_col;
					console_step(r);
					void'(pending_reqs.pop_front());
					gap_count <= 0;
				end
			end
			text_attr_we <= we_n;
			idle_count <= idle_n;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			console_view_t v;
			if (expected_views.size() == 0) begin
				flag_mismatch("result with nothing expected");
			end else begin
				v = expected_views.pop_front();
				if (cell_char !== v.cell_char)
					flag_mismatch($sformatf("cell_char %h want %h", cell_char, v.cell_char));
				if (cell_attr !== v.cell_attr)
					flag_mismatch($sformatf("cell_attr %h want %h", cell_attr, v.cell_attr));
				if (cursor_col_out !== v.col)
					flag_mismatch($sformatf("col %0d want %0d", cursor_col_out, v.col));
				if (cursor_row_out !== v.row)
					flag_mismatch($sformatf("row %0d want %0d", cursor_row_out, v.row));
			end
		end
	end

	task automatic add_req(input logic [1:0] a, input logic [7:0] c,
			input logic [4:0] rr, input logic [6:0] rc, input int g, input bit dr);
		console_req_t r;
		r.is_attr_write = 0;
		r.drain = dr;
		r.gap = g;
		r.action = a;
		r.char_code = c;
		r.read_row = rr;
		r.read_col = rc;
		r.attr = 0;
		pending_reqs.push_back(r);
	endtask

	task automatic add_attr_write(input logic [7:0] value);
		console_req_t r;
		r.is_attr_write = 1;
		r.drain = 0;
		r.gap = 0;
		r.action = 0;
		r.char_code = 0;
		r.read_row = 0;
		r.read_col = 0;
		r.attr = value;
		pending_reqs.push_back(r);
	endtask

	task automatic add_random_req();
		int p, g;
		bit dr;
		logic [7:0] c;
		p = $urandom_range(0, 99);
		g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		dr = ($urandom_range(0, 99) == 0);
		if (p < 80) begin
			case ($urandom_range(0, 19))
				0: c = tcw_pkg::CH_NL;
				1: c = tcw_pkg::CH_CR;
				2, 3: c = tcw_pkg::CH_TAB;
				4, 5: c = tcw_pkg::CH_BS;
				default: c = 8'($urandom_range(0, 255));
			endcase
			add_req(tcw_pkg::ACT_PUT, c, 5'($urandom), 7'($urandom), g, dr);
		end else if (p < 96) begin
			if ($urandom_range(0, 4) == 0)
				add_req(tcw_pkg::ACT_READ, 8'($urandom), 5'($urandom), 7'($urandom), g, dr);
			else
				add_req(tcw_pkg::ACT_READ, 8'($urandom),
					5'($urandom_range(0, tcw_pkg::ROWS - 1)),
					7'($urandom_range(0, tcw_pkg::COLS - 1)), g, dr);
		end else if (p < 98) begin
			add_req(ACT_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom), g, dr);
		end else begin
			add_req(tcw_pkg::ACT_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom), g, dr);
		end
	endtask

	initial begin
		shadow_attr = tcw_pkg::ATTR_RESET;
		shadow_col = 0;
		shadow_row = 0;
		for (int i = 0; i < tcw_pkg::CELLS; i++)
			shadow_screen[i] = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE};

		add_req(tcw_pkg::ACT_READ, 0, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, 8'h00, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, 8'hff, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, "A", 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, tcw_pkg::CH_TAB, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, tcw_pkg::CH_CR, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, tcw_pkg::CH_NL, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_PUT, tcw_pkg::CH_BS, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_READ, 0, 0, 0, 0, 0);
		add_req(tcw_pkg::ACT_READ, 0, 0, 1, 0, 0);
		add_req(tcw_pkg::ACT_READ, 0, 5'(tcw_pkg::ROWS - 1), 7'(tcw_pkg::COLS - 1), 0, 0);
		add_req(tcw_pkg::ACT_READ, 0, 5'd31, 7'd127, 0, 0);
		add_req(tcw_pkg::ACT_READ, 0, 5'(tcw_pkg::ROWS), 0, 0, 0);
		add_req(tcw_pkg::ACT_READ, 0, 0, 7'(tcw_pkg::COLS), 0, 0);
		add_req(ACT_UNUSED, 8'hff, 5'd31, 7'd127, 0, 0);
		add_req(tcw_pkg::ACT_CLEAR, 0, 0, 0, 0, 1);
		add_req(tcw_pkg::ACT_READ, 0, 0, 0, 0, 0);

		add_attr_write(8'hff);
		for (int i = 0; i < 170; i++) add_random_req();
		add_attr_write(8'h00);
		add_req(tcw_pkg::ACT_PUT, "z", 0, 0, 5, 1);
		for (int i = 0; i < 170; i++) add_random_req();
		add_attr_write(8'($urandom_range(0, 255)));
		for (int i = 0; i < 170; i++) add_random_req();
		add_attr_write(8'($urandom_range(0, 255)));
		for (int i = 0; i < 170; i++) add_random_req();

		repeat (4) @(posedge clk);
		arst_n <= 1;
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_views.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("text_console_char_writer_top_tb: PASS");
		else
			$display("text_console_char_writer_top_tb: FAIL");
		$finish;
	end

	initial begin
		#500ms;
		$display("text_console_char_writer_top_tb: FAIL");
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_char_writer_top.sv
tb/sv/text_console_char_writer_top_tb.sv
